[hw/rtl/assert_macros.svh]
// Assertion macros for the top-level RTL file.
// Depends on nothing; included by the top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Implication checked on every clock edge, reset included.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hw/rtl/bdta_pkg.sv]
// Package for the bus domain timing arbiter: types, constants, functions.
// Used by every module of the block; depends on nothing.
package bdta_pkg;

    localparam int DOMAINS  = 5;
    localparam int MAX_SET  = 8;
    localparam int DOM_W    = $clog2(DOMAINS);
    localparam int POS_W    = $clog2(MAX_SET + 1);
    localparam int IN_W     = 208;
    localparam int OUT_W    = 104;
    localparam logic [31:0] SAT32 = 32'hFFFF_FFFF;

    typedef enum logic [1:0] {
        FN_QUERY  = 2'd0,
        FN_GRANT  = 2'd1,
        FN_REBASE = 2'd2,
        FN_PICK   = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_OUT
    } t_state;

    typedef enum logic [0:0] {
        REG_SAME_ADDR = 1'b0,
        REG_TIE       = 1'b1
    } t_reg;

    typedef struct packed {
        logic [1:0]  func;
        logic [31:0] addr;
        logic [1:0]  master;
        logic        wr_flag;
        logic [2:0]  xfer_size;
        logic [63:0] tick;
        logic        had_tie;
        logic [31:0] svc_cycles;
        logic [63:0] max_ahead;
        logic        first_in_set;
        logic        last_in_set;
    } t_req;

    typedef struct packed {
        logic        must_stall;
        logic [31:0] stall_cycles;
        logic [63:0] free_tick;
        logic        rebased;
        logic [2:0]  winner_index;
    } t_res;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic exec;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic emit;
    } t_sts;

    function automatic logic [DOM_W-1:0] decode_domain(input logic [31:0] a);
        logic [DOM_W-1:0] d;
        if (a <= 32'h00F_FFFF) d = DOM_W'(0);
        else if (a >= 32'h020_0000 && a <= 32'h02F_FFFF) d = DOM_W'(1);
        else if (a >= 32'h200_0000 && a <= 32'h4FF_FFFF) d = DOM_W'(2);
        else if (a >= 32'h5A0_0000 && a <= 32'h5FB_FFFF) d = DOM_W'(4);
        else if (a >= 32'h600_0000 && a <= 32'h7FF_FFFF) d = DOM_W'(3);
        else d = DOM_W'(4);
        return d;
    endfunction

    function automatic logic [1:0] prio_of(input logic [1:0] m);
        logic [1:0] p;
        if (m == 2'd2) p = 2'd2;
        else if (m <= 2'd1) p = 2'd1;
        else p = 2'd0;
        return p;
    endfunction

endpackage

[hw/rtl/bdta_ctrl.sv]
// Controller of the bus domain timing arbiter: load, execute, deliver.
// Depends on bdta_pkg.
module bdta_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    input  bdta_pkg::t_sts    i_sts,
    output bdta_pkg::t_cmd    o_cmd
);
    bdta_pkg::t_state r_state, n_state;

    // hold state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= bdta_pkg::ST_IDLE;
        else          r_state <= n_state;
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            bdta_pkg::ST_IDLE: begin
                if (i_in_valid) n_state = bdta_pkg::ST_EXEC;
            end
            bdta_pkg::ST_EXEC: begin
                n_state = i_sts.emit ? bdta_pkg::ST_OUT : bdta_pkg::ST_IDLE;
            end
            bdta_pkg::ST_OUT: begin
                if (i_out_ready) n_state = bdta_pkg::ST_IDLE;
            end
            default: n_state = bdta_pkg::ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        o_cmd       = '0;
        case (r_state)
            bdta_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            bdta_pkg::ST_EXEC: o_cmd.exec = 1'b1;
            bdta_pkg::ST_OUT:  o_out_valid = 1'b1;
            default: o_in_ready = 1'b0;
        endcase
    end
endmodule

[hw/rtl/bdta_dp.sv]
// Datapath of the bus domain timing arbiter: domain file, pick state, result.
// Depends on bdta_pkg.
module bdta_dp (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  bdta_pkg::t_cmd    i_cmd,
    output bdta_pkg::t_sts    o_sts,
    input  bdta_pkg::t_req    i_req,
    input  logic [15:0]       i_same_pen,
    input  logic [15:0]       i_tie_pen,
    output bdta_pkg::t_res    o_res
);
    localparam int D = bdta_pkg::DOMAINS;
    localparam int PW = bdta_pkg::POS_W;

    bdta_pkg::t_req              r_req;
    logic [bdta_pkg::DOM_W-1:0]  r_dom;
    logic [63:0]                 r_free [D];
    logic [D-1:0]                r_has;
    logic [31:0]                 r_laddr [D];
    logic [1:0]                  r_lmst [D];
    logic                        r_cpu_vld, r_cpu_id;
    logic [31:0]                 r_b_addr;
    logic [1:0]                  r_b_mst;
    logic                        r_b_wr;
    logic [2:0]                  r_b_size;
    logic [PW-1:0]               r_b_pos, r_set_pos;
    bdta_pkg::t_res              r_res;
    bdta_pkg::t_res              n_res;
    logic [PW-1:0]               n_b_pos, n_set_pos;

    logic [63:0] w_free, w_start, w_dur, w_new, w_delta;
    logic        w_same, w_beats, w_open, w_rebase, w_take;
    logic [1:0]  w_cp, w_bp;
    logic        w_pref;

    // domain view of the loaded request
    always_comb begin
        w_free  = r_free[r_dom];
        w_start = (r_req.tick > w_free) ? r_req.tick : w_free;
        w_same  = r_has[r_dom] && (r_laddr[r_dom] == r_req.addr)
                  && (r_lmst[r_dom] != r_req.master);
        w_dur   = (r_req.svc_cycles == 32'd0) ? 64'd1 : {32'd0, r_req.svc_cycles};
        w_dur   = w_dur + (w_same ? {48'd0, i_same_pen} : 64'd0)
                        + (r_req.had_tie ? {48'd0, i_tie_pen} : 64'd0);
        w_new   = w_start + w_dur;
        w_delta = w_free - r_req.tick;
        w_rebase = (w_free > r_req.tick) && (w_delta > r_req.max_ahead);
    end

    // candidate against current best
    always_comb begin
        w_cp   = bdta_pkg::prio_of(r_req.master);
        w_bp   = bdta_pkg::prio_of(r_b_mst);
        w_pref = r_cpu_vld ? ~r_cpu_id : 1'b0;
        if (w_cp != w_bp) w_beats = w_cp > w_bp;
        else if (r_req.master != 2'd2 && r_b_mst != 2'd2 && r_req.master != r_b_mst)
            w_beats = r_req.master == {1'b0, w_pref};
        else if (r_req.master != r_b_mst) w_beats = r_req.master < r_b_mst;
        else if (r_req.addr != r_b_addr) w_beats = r_req.addr < r_b_addr;
        else if (r_req.wr_flag != r_b_wr) w_beats = r_req.wr_flag;
        else w_beats = r_req.xfer_size < r_b_size;
        w_open = r_req.first_in_set || (r_set_pos == '0);
    end

    // next result and pick bookkeeping
    always_comb begin
        n_res           = '0;
        n_res.free_tick = w_free;
        n_b_pos         = r_b_pos;
        n_set_pos       = r_set_pos;
        w_take          = 1'b0;
        case (bdta_pkg::t_func'(r_req.func))
            bdta_pkg::FN_QUERY: begin
                if (r_req.tick < w_free) begin
                    n_res.must_stall   = 1'b1;
                    n_res.stall_cycles = (w_delta[63:32] != 32'd0) ?
                                         bdta_pkg::SAT32 : w_delta[31:0];
                end
            end
            bdta_pkg::FN_GRANT: n_res.free_tick = w_new;
            bdta_pkg::FN_REBASE: begin
                if (w_rebase) begin
                    n_res.rebased   = 1'b1;
                    n_res.free_tick = r_req.tick;
                end
            end
            bdta_pkg::FN_PICK: begin
                n_res.free_tick = '0;
                if (w_open) begin
                    w_take    = 1'b1;
                    n_b_pos   = '0;
                    n_set_pos = PW'(1);
                end else if (r_set_pos < PW'(bdta_pkg::MAX_SET)) begin
                    if (w_beats) begin
                        w_take  = 1'b1;
                        n_b_pos = r_set_pos;
                    end
                    n_set_pos = r_set_pos + PW'(1);
                end
                if (r_req.last_in_set) n_set_pos = '0;
                n_res.winner_index = n_b_pos[2:0];
            end
            default: n_res = '0;
        endcase
    end

    assign o_sts.emit = (r_req.func != bdta_pkg::FN_PICK) || r_req.last_in_set;
    assign o_res = r_res;

    // capture request
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req <= i_req;
            r_dom <= bdta_pkg::decode_domain(i_req.addr);
        end
    end

    // execute one operation
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < D; i++) begin
                r_free[i]  <= '0;
                r_laddr[i] <= '0;
                r_lmst[i]  <= '0;
            end
            r_has     <= '0;
            r_cpu_vld <= 1'b0;
            r_cpu_id  <= 1'b0;
            r_b_addr  <= '0;
            r_b_mst   <= '0;
            r_b_wr    <= 1'b0;
            r_b_size  <= '0;
            r_b_pos   <= '0;
            r_set_pos <= '0;
        end else if (i_cmd.exec) begin
            r_res <= n_res;
            case (bdta_pkg::t_func'(r_req.func))
                bdta_pkg::FN_QUERY: ;
                bdta_pkg::FN_GRANT: begin
                    r_free[r_dom]  <= w_new;
                    r_has[r_dom]   <= 1'b1;
                    r_laddr[r_dom] <= r_req.addr;
                    r_lmst[r_dom]  <= r_req.master;
                    if (r_req.master <= 2'd1) begin
                        r_cpu_vld <= 1'b1;
                        r_cpu_id  <= r_req.master[0];
                    end
                end
                bdta_pkg::FN_REBASE: begin
                    if (w_rebase) begin
                        r_free[r_dom]  <= r_req.tick;
                        r_has[r_dom]   <= 1'b0;
                        r_laddr[r_dom] <= '0;
                        r_lmst[r_dom]  <= '0;
                    end
                end
                bdta_pkg::FN_PICK: begin
                    if (w_take) begin
                        r_b_addr <= r_req.addr;
                        r_b_mst  <= r_req.master;
                        r_b_wr   <= r_req.wr_flag;
                        r_b_size <= r_req.xfer_size;
                    end
                    r_b_pos   <= n_b_pos;
                    r_set_pos <= n_set_pos;
                end
                default: ;
            endcase
        end
    end
endmodule

[hw/rtl/bus_domain_timing_arbiter.sv]
// Top level of the bus domain timing arbiter: stream ports, APB registers.
// Depends on bdta_pkg, bdta_ctrl, bdta_dp and assert_macros.svh.
//
// Usage:
//  - Requests enter on s_axis (tdata packs func, addr, master, wr_flag,
//    xfer_size, tick, had_tie, svc_cycles, max_ahead, first_in_set,
//    last_in_set from bit 0 up). Results leave on m_axis.
//  - func 0 queries the wait on the address's domain, 1 books a grant,
//    2 rebases a domain, 3 streams one request of a pick set; only the
//    request that closes a set gives a result (winner_index).
//  - A request is captured at its handshake and executed on the five-entry
//    domain file at the next edge; its result is offered from then on.
//  - One request is in flight at a time: a new request is taken only once
//    the last one has delivered its result, or once it has executed if it
//    is a pick request that does not close its set.
//  - A stalled result holds m_axis_tvalid and its data; no request is
//    taken until it is delivered.
//  - Reset clears all domain state, the pick set and both penalty
//    registers, which are written at APB byte addresses 0 and 4.
module bus_domain_timing_arbiter (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // func[1:0], addr[33:2], master[35:34], wr_flag[36], xfer_size[39:37],
    // tick[103:40], had_tie[104], svc_cycles[136:105], max_ahead[200:137],
    // first_in_set[201], last_in_set[202], zeros above
    input  logic [bdta_pkg::IN_W-1:0]  s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // must_stall[0], stall_cycles[32:1], free_tick[96:33], rebased[97],
    // winner_index[100:98], zeros above
    output logic [bdta_pkg::OUT_W-1:0] m_axis_tdata,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    bdta_pkg::t_cmd w_cmd;
    bdta_pkg::t_sts w_sts;
    bdta_pkg::t_req w_req;
    bdta_pkg::t_res w_res;
    logic [15:0]    r_same_pen, r_tie_pen;

    // unpack request fields
    always_comb begin
        w_req.func          = s_axis_tdata[1:0];
        w_req.addr          = s_axis_tdata[33:2];
        w_req.master        = s_axis_tdata[35:34];
        w_req.wr_flag       = s_axis_tdata[36];
        w_req.xfer_size     = s_axis_tdata[39:37];
        w_req.tick          = s_axis_tdata[103:40];
        w_req.had_tie       = s_axis_tdata[104];
        w_req.svc_cycles    = s_axis_tdata[136:105];
        w_req.max_ahead     = s_axis_tdata[200:137];
        w_req.first_in_set  = s_axis_tdata[201];
        w_req.last_in_set   = s_axis_tdata[202];
    end

    assign m_axis_tdata = {3'd0, w_res.winner_index, w_res.rebased, w_res.free_tick,
                           w_res.stall_cycles, w_res.must_stall};

    // register file
    assign pready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_same_pen <= '0;
            r_tie_pen  <= '0;
        end else if (psel && penable && pwrite && paddr[1:0] == 2'd0 && !paddr[2]) begin
            r_same_pen <= pwdata[15:0];
        end else if (psel && penable && pwrite && paddr[1:0] == 2'd0 && paddr[2]) begin
            r_tie_pen <= pwdata[15:0];
        end
    end

    always_comb begin
        case (bdta_pkg::t_reg'(paddr[2]))
            bdta_pkg::REG_SAME_ADDR: prdata = {16'd0, r_same_pen};
            bdta_pkg::REG_TIE:       prdata = {16'd0, r_tie_pen};
            default:                 prdata = '0;
        endcase
    end

    bdta_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    bdta_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .o_sts      (w_sts),
        .i_req      (w_req),
        .i_same_pen (r_same_pen),
        .i_tie_pen  (r_tie_pen),
        .o_res      (w_res)
    );

`include "assert_macros.svh"

    `ASSERT_CLK(a_no_load_busy, i_clk, i_rst_n, w_cmd.load |-> !m_axis_tvalid, "load while busy")
    `ASSERT_CLK(a_out_after_exec, i_clk, i_rst_n, $rose(m_axis_tvalid) |-> $past(w_cmd.exec), "no exec")
    `ASSERT_CLK(a_exec_after_load, i_clk, i_rst_n, w_cmd.exec |-> $past(w_cmd.load), "no load")
    `ASSERT_CLK(a_ready_excl, i_clk, i_rst_n, !(s_axis_tready && m_axis_tvalid), "ready while busy")
    `ASSERT_ALWAYS(a_reset_idle, i_clk, !i_rst_n |=> !m_axis_tvalid, "result after reset")
endmodule

[verif/testbench.sv]
// Testbench for the bus domain timing arbiter: drives requests on the input stream,
// predicts every result in a local model of the domain timing and pick logic, and checks each.
// Depends on bdta_pkg and bus_domain_timing_arbiter.
`timescale 1ns / 1ps

module testbench;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    // func, addr, master, wr_flag, xfer_size, tick, had_tie, svc_cycles,
    // max_ahead, first_in_set, last_in_set from bit 0 up, zeros above
    logic [bdta_pkg::IN_W-1:0]  s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    // must_stall, stall_cycles, free_tick, rebased, winner_index from bit 0 up
    logic [bdta_pkg::OUT_W-1:0] m_axis_tdata;
    logic         psel;
    logic         penable;
    logic         pwrite;
    logic [2:0]   paddr;
    logic [31:0]  pwdata;
    logic [31:0]  prdata;
    logic         pready;

    bus_domain_timing_arbiter u_dut (.*);

    typedef struct packed {
        logic [31:0] addr;
        logic [1:0]  master;
        logic        wr;
        logic [2:0]  size;
    } t_cand;

    // model state
    logic [63:0] free_tick_m [bdta_pkg::DOMAINS];
    logic        has_last_m [bdta_pkg::DOMAINS];
    logic [31:0] last_addr_m [bdta_pkg::DOMAINS];
    logic [1:0]  last_master_m [bdta_pkg::DOMAINS];
    logic        cpu_valid_m;
    logic        cpu_id_m;
    t_cand       best_m;
    int          best_pos_m;
    int          set_pos_m;
    logic [15:0] same_pen_m;
    logic [15:0] tie_pen_m;

    bdta_pkg::t_req   pending_reqs[$];
    bdta_pkg::t_res   expected_results[$];
    bdta_pkg::t_req   cur_req;
    int     mismatches;
    int     results_seen;
    int     sent;
    int     send_idle_pct;
    int     recv_stall_pct;
    logic   burst_go;
    logic   stall_hold;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int domain_of(input logic [31:0] a);
        if (a <= 32'h00F_FFFF) return 0;
        if (a >= 32'h020_0000 && a <= 32'h02F_FFFF) return 1;
        if (a >= 32'h200_0000 && a <= 32'h4FF_FFFF) return 2;
        if (a >= 32'h5A0_0000 && a <= 32'h5FB_FFFF) return 4;
        if (a >= 32'h600_0000 && a <= 32'h7FF_FFFF) return 3;
        return 4;
    endfunction

    function automatic int rank_of(input logic [1:0] m);
        if (m == 2'd2) return 2;
        if (m <= 2'd1) return 1;
        return 0;
    endfunction

    // Pack a request into the stream word, first field in the lowest bits.
    function automatic logic [bdta_pkg::IN_W-1:0] pack_req(input bdta_pkg::t_req r);
        return {5'd0, r.last_in_set, r.first_in_set, r.max_ahead, r.svc_cycles,
                r.had_tie, r.tick, r.xfer_size, r.wr_flag, r.master, r.addr, r.func};
    endfunction

    // Unpack a result word, first field in the lowest bits.
    function automatic bdta_pkg::t_res unpack_res(input logic [bdta_pkg::OUT_W-1:0] d);
        bdta_pkg::t_res res;
        res.must_stall   = d[0];
        res.stall_cycles = d[32:1];
        res.free_tick    = d[96:33];
        res.rebased      = d[97];
        res.winner_index = d[100:98];
        return res;
    endfunction

    function automatic bit cand_wins(input t_cand c, input t_cand b);
        logic [1:0] pref;
        if (rank_of(c.master) != rank_of(b.master))
            return rank_of(c.master) > rank_of(b.master);
        if (c.master != 2'd2 && b.master != 2'd2 && c.master != b.master) begin
            pref = (cpu_valid_m && cpu_id_m == 1'b0) ? 2'd1 : 2'd0;
            return c.master == pref;
        end
        if (c.master != b.master) return c.master < b.master;
        if (c.addr != b.addr) return c.addr < b.addr;
        if (c.wr != b.wr) return c.wr;
        return c.size < b.size;
    endfunction

    // Advance the model by one request; queue the result it causes, if any.
    task automatic predict_arbiter(input bdta_pkg::t_req r);
        int             d;
        logic [63:0]    f;
        logic [63:0]    start;
        logic [63:0]    dur;
        bdta_pkg::t_res res;
        t_cand          c;
        d = domain_of(r.addr);
        f = free_tick_m[d];
        res = '0;
        case (bdta_pkg::t_func'(r.func))
            bdta_pkg::FN_QUERY: begin
                if (r.tick < f) begin
                    res.must_stall = 1'b1;
                    res.stall_cycles = (f - r.tick > 64'hFFFF_FFFF) ? bdta_pkg::SAT32
                                                                   : 32'(f - r.tick);
                end
                res.free_tick = f;
                expected_results.push_back(res);
            end
            bdta_pkg::FN_GRANT: begin
                start = (r.tick > f) ? r.tick : f;
                dur = (r.svc_cycles != 0) ? 64'(r.svc_cycles) : 64'd1;
                if (has_last_m[d] && last_addr_m[d] == r.addr && last_master_m[d] != r.master)
                    dur += 64'(same_pen_m);
                if (r.had_tie) dur += 64'(tie_pen_m);
                free_tick_m[d] = start + dur;
                has_last_m[d] = 1'b1;
                last_addr_m[d] = r.addr;
                last_master_m[d] = r.master;
                if (r.master <= 2'd1) begin
                    cpu_valid_m = 1'b1;
                    cpu_id_m = r.master[0];
                end
                res.free_tick = free_tick_m[d];
                expected_results.push_back(res);
            end
            bdta_pkg::FN_REBASE: begin
                if (f > r.tick && f - r.tick > r.max_ahead) begin
                    free_tick_m[d] = r.tick;
                    has_last_m[d] = 1'b0;
                    last_addr_m[d] = '0;
                    last_master_m[d] = '0;
                    res.rebased = 1'b1;
                end
                res.free_tick = free_tick_m[d];
                expected_results.push_back(res);
            end
            default: begin
                c = '{addr: r.addr, master: r.master, wr: r.wr_flag, size: r.xfer_size};
                if (r.first_in_set || set_pos_m == 0) begin
                    best_m = c;
                    best_pos_m = 0;
                    set_pos_m = 1;
                end else if (set_pos_m < bdta_pkg::MAX_SET) begin
                    if (cand_wins(c, best_m)) begin
                        best_m = c;
                        best_pos_m = set_pos_m;
                    end
                    set_pos_m++;
                end
                if (r.last_in_set) begin
                    res.winner_index = 3'(best_pos_m);
                    set_pos_m = 0;
                    expected_results.push_back(res);
                end
            end
        endcase
    endtask

    // Addresses biased toward domain edges and a few hot spots.
    function automatic logic [31:0] pick_addr();
        case ($urandom_range(0, 9))
            0: return 32'h000_0000 + $urandom_range(0, 3);
            1: return 32'h00F_FFFF + $urandom_range(0, 1);
            2: return 32'h01F_FFFF + $urandom_range(0, 1) * 32'h10_0001;
            3: return 32'h200_0000 - $urandom_range(0, 1);
            4: return 32'h4FF_FFFF + $urandom_range(0, 1);
            5: return 32'h59F_FFFF + $urandom_range(0, 1) * 32'h5_C001;
            6: return 32'h5FF_FFFF + $urandom_range(0, 1);
            7: return 32'h7FF_FFFF + $urandom_range(0, 1);
            8: return $urandom;
            default: return 32'h600_0010 + $urandom_range(0, 1) * 32'h4;
        endcase
    endfunction

    function automatic bdta_pkg::t_req rand_req(input logic [1:0] fn);
        bdta_pkg::t_req r;
        r.func = fn;
        r.addr = pick_addr();
        r.master = $urandom_range(0, 9) == 0 ? 2'd3 : 2'($urandom_range(0, 2));
        r.wr_flag = 1'($urandom_range(0, 1));
        r.xfer_size = $urandom_range(0, 9) == 0 ? 3'($urandom) : 3'($urandom_range(1, 4));
        r.tick = $urandom_range(0, 15) == 0 ? {$urandom, $urandom}
                                            : 64'($urandom_range(0, 4000));
        r.had_tie = 1'($urandom_range(0, 1));
        r.svc_cycles = $urandom_range(0, 15) == 0 ? $urandom : $urandom_range(0, 60);
        r.max_ahead = $urandom_range(0, 15) == 0 ? {$urandom, $urandom}
                                                 : 64'($urandom_range(0, 200));
        r.first_in_set = 1'($urandom_range(0, 1));
        r.last_in_set = 1'($urandom_range(0, 1));
        return r;
    endfunction

    // Queue a well-formed pick set of n requests, with an occasional broken opening.
    task automatic add_pick_set(input int n);
        bdta_pkg::t_req r;
        for (int k = 0; k < n; k++) begin
            r = rand_req(bdta_pkg::FN_PICK);
            r.first_in_set = (k == 0) ? ($urandom_range(0, 7) != 0) : 1'b0;
            r.last_in_set = (k == n - 1);
            pending_reqs.push_back(r);
        end
    endtask

    // Write one penalty register over APB, read it back, then mirror it in the model.
    task automatic write_reg(input bdta_pkg::t_reg idx, input logic [15:0] val);
        @(posedge i_clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= 3'(idx) << 2; pwdata <= {16'($urandom), val};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        penable <= 1'b0; pwrite <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (!pready || prdata !== {16'd0, val}) begin
            mismatches++;
            if (mismatches <= 10)
                $display("register %0d: exp %h, got %h", idx, {16'd0, val}, prdata);
        end
        psel <= 1'b0; penable <= 1'b0;
        if (idx == bdta_pkg::REG_SAME_ADDR) same_pen_m = val;
        else tie_pen_m = val;
    endtask

    task automatic wait_drained();
        while (pending_reqs.size() != 0 || expected_results.size() != 0 || s_axis_tvalid)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    // driver: offer queued requests, idling at the phase's rate
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if (s_axis_tvalid) begin
                predict_arbiter(cur_req);
                sent++;
            end
            if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                cur_req = pending_reqs.pop_front();
                s_axis_tdata <= pack_req(cur_req);
                s_axis_tvalid <= 1'b1;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // long receiver stall in the first random phase, while the sender keeps offering
    initial begin
        stall_hold = 1'b0;
        wait (burst_go === 1'b1);
        repeat (20) @(posedge i_clk);
        stall_hold <= 1'b1;
        repeat (300) @(posedge i_clk);
        stall_hold <= 1'b0;
    end

    // monitor: check each delivered result against the oldest expectation
    always @(posedge i_clk) begin
        bdta_pkg::t_res got;
        bdta_pkg::t_res exp_r;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                got = unpack_res(m_axis_tdata);
                results_seen++;
                if (expected_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected result %h", got);
                end else begin
                    exp_r = expected_results.pop_front();
                    if (got !== exp_r) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"mismatch: exp wait=%0d/%0d free=%0d reb=%0d win=%0d,",
                                      " got wait=%0d/%0d free=%0d reb=%0d win=%0d"},
                                exp_r.must_stall, exp_r.stall_cycles, exp_r.free_tick,
                                exp_r.rebased, exp_r.winner_index, got.must_stall,
                                got.stall_cycles, got.free_tick, got.rebased,
                                got.winner_index);
                    end
                end
            end
            if (stall_hold) begin
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
            end
        end
    end

    initial begin
        #100_000_000;
        $display("testbench: FAIL");
        $finish;
    end

    initial begin
        bdta_pkg::t_req r;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        mismatches = 0; results_seen = 0; sent = 0;
        send_idle_pct = 0; recv_stall_pct = 0; burst_go = 1'b0;
        for (int d = 0; d < bdta_pkg::DOMAINS; d++) begin
            free_tick_m[d] = '0; has_last_m[d] = 1'b0;
            last_addr_m[d] = '0; last_master_m[d] = '0;
        end
        cpu_valid_m = 1'b0; cpu_id_m = 1'b0; best_m = '0; best_pos_m = 0; set_pos_m = 0;
        same_pen_m = '0; tie_pen_m = '0;
        i_rst_n = 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: extremes, overflow, pick without open set, set overflow
        r = rand_req(bdta_pkg::FN_PICK); r.first_in_set = 0; r.last_in_set = 1;
        pending_reqs.push_back(r);
        r = '0; r.func = bdta_pkg::FN_QUERY; pending_reqs.push_back(r);
        r = '0; r.func = bdta_pkg::FN_GRANT; r.addr = 32'hFFFF_FFFF; r.master = 2'd3;
        r.tick = 64'hFFFF_FFFF_FFFF_FFF0; r.svc_cycles = 32'hFFFF_FFFF; r.had_tie = 1;
        pending_reqs.push_back(r);
        r.func = bdta_pkg::FN_QUERY; r.tick = 0; pending_reqs.push_back(r);
        r.func = bdta_pkg::FN_REBASE; r.max_ahead = 64'hFFFF_FFFF_FFFF_FFFF;
        pending_reqs.push_back(r);
        r = '0; r.func = bdta_pkg::FN_GRANT; r.addr = 32'h600_0000; r.master = 2'd2;
        r.tick = 64'd100; pending_reqs.push_back(r);
        r.master = 2'd1; r.had_tie = 1; pending_reqs.push_back(r);
        r.func = bdta_pkg::FN_REBASE; r.tick = 64'd0; r.max_ahead = 64'd1;
        pending_reqs.push_back(r);
        r = '0; r.func = bdta_pkg::FN_QUERY; r.addr = 32'h5A0_0000;
        r.tick = 64'hFFFF_FFFF_FFFF_FFFF; pending_reqs.push_back(r);
        for (int k = 0; k < 10; k++) begin
            r = rand_req(bdta_pkg::FN_PICK);
            r.first_in_set = (k == 0); r.last_in_set = (k == 9);
            r.xfer_size = 3'(k); r.master = 2'(k);
            pending_reqs.push_back(r);
        end
        wait_drained();

        // random phases over several penalty settings and idle patterns
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: begin
                    write_reg(bdta_pkg::REG_SAME_ADDR, 16'hFFFF);
                    write_reg(bdta_pkg::REG_TIE, 16'd0);
                end
                1: begin
                    write_reg(bdta_pkg::REG_SAME_ADDR, 16'd0);
                    write_reg(bdta_pkg::REG_TIE, 16'hFFFF);
                end
                default: begin
                    write_reg(bdta_pkg::REG_SAME_ADDR, 16'($urandom_range(0, 20)));
                    write_reg(bdta_pkg::REG_TIE, 16'($urandom_range(0, 20)));
                end
            endcase
            send_idle_pct = (ph == 2 || ph == 5) ? 30 : (ph == 3 ? 61 : 0);
            recv_stall_pct = (ph == 4 || ph == 5) ? 30 : (ph == 1 ? 61 : 0);
            if (ph == 2) send_idle_pct = 61;
            if (ph == 4) recv_stall_pct = 61;
            while (pending_reqs.size() < 315) begin
                if ($urandom_range(0, 3) == 0)
                    add_pick_set($urandom_range(0, 9) == 0 ? $urandom_range(8, 11)
                                                           : $urandom_range(1, 5));
                else
                    pending_reqs.push_back(rand_req(2'($urandom_range(0, 2))));
            end
            if (ph == 0) burst_go = 1'b1;
            wait_drained();
        end

        $display("covered %0d requests and %0d results across six idle/penalty phases",
                 sent, results_seen);
        if (mismatches == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule

[filelist.f]
+incdir+hw/rtl
hw/rtl/bdta_pkg.sv
hw/rtl/bdta_ctrl.sv
hw/rtl/bdta_dp.sv
hw/rtl/bus_domain_timing_arbiter.sv
verif/testbench.sv
